>>> rtl/ltc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and elaboration helpers for the load throttle controller.
// Used by ltc_cdiv and load_throttle_controller_unit; depends on nothing else.
package ltc_pkg;

	// Field widths of the transaction payloads and registers.
	localparam int FRAME_TIME_W = 20;
	localparam int TARGET_W     = 14;
	localparam int LEVEL_W      = 9;
	localparam int EVENT_W      = 2;

	// Defaults of the top level parameters.
	localparam int TRAILING_FRAMES_N_DEF = 112;
	localparam int FRAC_BITS_DEF         = 16;

	// Throttle law.
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd320;
	localparam int RAISE_STEP    = 8;
	localparam int LOWER_STEP    = 2;
	localparam int RAISE_SPAN_US = 1000;
	localparam int LOWER_SPAN_US = 2000;
	// A raise multiplier beyond this always saturates the level.
	localparam int RAISE_K_MAX   = 40;
	localparam int RAISE_K_W     = 6;
	// The lowering multiplier never exceeds 8 since targets are 14 bits.
	localparam int LOWER_K_W     = 4;

	// Register reset values.
	localparam logic [TARGET_W-1:0] START_TARGET_RST   = 14'd9000;
	localparam logic [TARGET_W-1:0] BACKOFF_TARGET_RST = 14'd4400;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_START_TARGET   = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BACKOFF_TARGET = 1'b1;

	typedef enum logic [EVENT_W-1:0] {
		EVT_NONE  = 2'd0,
		EVT_RAISE = 2'd1,
		EVT_LOWER = 2'd2
	} adjust_evt_t;

	// Number of trailing zero bits of a positive constant; elaboration only.
	function automatic int ctz(input int value);
		int n;
		n = 0;
		for (int i = 0; i < 30; i++) begin
			if (((value >> n) & 1) == 0) begin
				n = n + 1;
			end
		end
		return n;
	endfunction

endpackage

>>> rtl/ltc_cdiv.sv
`timescale 1ns / 1ps
// Unsigned floor division by a constant: power-of-two factor as a shift, odd rest
// by an exact reciprocal multiply. Depends on ltc_pkg.
module ltc_cdiv #(
	parameter int XW  = ltc_pkg::FRAME_TIME_W,
	parameter int DIV = ltc_pkg::RAISE_SPAN_US
) (
	input  logic [XW-1:0] x,
	output logic [XW-1:0] q
);
	import ltc_pkg::*;

	localparam int S   = ctz(DIV);
	localparam int ODD = DIV >> S;
	localparam int DW  = XW - S;
	localparam int L   = $clog2(ODD);
	localparam int MW  = DW + 1;
	localparam int PW  = DW + MW;
	// ceil(2^(DW+L) / ODD) gives an exact quotient for every DW-bit dividend.
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << (DW + L)) + 64'(ODD) - 64'd1) / 64'(ODD);
	localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

	logic [DW-1:0] x_odd;
	logic [PW-1:0] prod;

	assign x_odd = x[XW-1:S];
	assign prod  = PW'(x_odd) * PW'(RECIP);
	assign q     = XW'(prod[PW-1:DW+L]);

endmodule

>>> rtl/load_throttle_controller_unit.sv
`timescale 1ns / 1ps
// Load throttle controller: moving average of frame time and periodic throttle update.
// One frame transaction is taken every cycle unless the result channel stalls, set by the
// average update loop (one reciprocal multiply, subtract and add per cycle). Reset clears
// all valid flags, the average and the throttle level, loads the frame phase with 2 mod
// TRAILING_FRAMES_N and the targets with 9000 and 4400. Depends on ltc_pkg and ltc_cdiv.
module load_throttle_controller_unit #(
	parameter int TRAILING_FRAMES_N = ltc_pkg::TRAILING_FRAMES_N_DEF,
	parameter int FRAC_BITS         = ltc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Frame channel
	input  logic                              frame_valid,
	output logic                              frame_stall,
	input  logic [ltc_pkg::FRAME_TIME_W-1:0]  frame_time_us,
	// Result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [ltc_pkg::LEVEL_W-1:0]       throttle_level,
	output logic [ltc_pkg::FRAME_TIME_W-1:0]  average_time_us,
	output logic [ltc_pkg::EVENT_W-1:0]       adjust_event,
	// Configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ltc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ltc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ltc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import ltc_pkg::*;

	localparam int AVG_W   = FRAME_TIME_W + FRAC_BITS;
	localparam int PHASE_W = $clog2(TRAILING_FRAMES_N);
	localparam logic [PHASE_W-1:0] PHASE_RST  = PHASE_W'(2 % TRAILING_FRAMES_N);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TRAILING_FRAMES_N - 1);

	// Configuration registers
	logic [TARGET_W-1:0]  start_target_q;
	logic [TARGET_W-1:0]  backoff_target_q;
	logic                 cfg_write;
	logic [REG_IDX_W-1:0] cfg_idx;

	// Pipeline
	logic                    valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                    en_s1, en_s2, en_s3, en_s4, en_s5;
	logic [FRAME_TIME_W-1:0] time_s1;
	logic [AVG_W-1:0]        time_fx;
	logic [AVG_W-1:0]        time_quot;
	logic [AVG_W-1:0]        time_quot_s2;
	logic [AVG_W-1:0]        avg_q;
	logic [AVG_W-1:0]        avg_quot;
	logic [AVG_W-1:0]        avg_next;
	logic [PHASE_W-1:0]      phase_q;
	logic                    act_s3;
	logic [AVG_W-1:0]        start_fx;
	logic [AVG_W-1:0]        backoff_fx;
	logic                    over_start;
	logic [AVG_W-1:0]        raise_diff;
	logic [AVG_W-1:0]        lower_diff;
	logic [FRAME_TIME_W-1:0] raise_k;
	logic [FRAME_TIME_W-1:0] lower_k;
	logic                    raise_s4;
	logic                    lower_s4;
	logic [RAISE_K_W-1:0]    raise_k_s4;
	logic [LOWER_K_W-1:0]    lower_k_s4;
	logic [FRAME_TIME_W-1:0] avg_us_s4;
	logic [LEVEL_W-1:0]      throttle_q;
	logic [FRAME_TIME_W-1:0] avg_us_s5;
	adjust_evt_t             event_s5;
	logic [LEVEL_W:0]        raise_inc;
	logic [LEVEL_W:0]        raise_sum;
	logic [LEVEL_W-1:0]      level_raised;
	logic [LOWER_K_W:0]      lower_dec;
	logic [LEVEL_W-1:0]      level_lowered;

	// ---------------- Configuration port ----------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_target_q   <= START_TARGET_RST;
			backoff_target_q <= BACKOFF_TARGET_RST;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_START_TARGET:   start_target_q   <= pwdata[TARGET_W-1:0];
				REG_BACKOFF_TARGET: backoff_target_q <= pwdata[TARGET_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_START_TARGET:   prdata = APB_DATA_W'(start_target_q);
			REG_BACKOFF_TARGET: prdata = APB_DATA_W'(backoff_target_q);
			default:            prdata = '0;
		endcase
	end

	// ---------------- Stage enables ----------------
	// A stage loads when it is empty or its content moves on, so bubbles collapse.
	assign en_s5 = !valid_s5 || !result_stall;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign frame_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= frame_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// ---------------- Stage 1: input register ----------------
	always_ff @(posedge clk) begin
		if (en_s1 && frame_valid) begin
			time_s1 <= frame_time_us;
		end
	end

	// ---------------- Stage 2: scaled frame time over N ----------------
	assign time_fx = {time_s1, {FRAC_BITS{1'b0}}};

	ltc_cdiv #(
		.XW  (AVG_W),
		.DIV (TRAILING_FRAMES_N)
	) u_time_div (
		.x (time_fx),
		.q (time_quot)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			time_quot_s2 <= time_quot;
		end
	end

	// ---------------- Stage 3: average update ----------------
	ltc_cdiv #(
		.XW  (AVG_W),
		.DIV (TRAILING_FRAMES_N)
	) u_avg_div (
		.x (avg_q),
		.q (avg_quot)
	);

	assign avg_next = avg_q - avg_quot + time_quot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q   <= '0;
			phase_q <= PHASE_RST;
			act_s3  <= 1'b0;
		end else if (en_s3 && valid_s2) begin
			avg_q   <= avg_next;
			act_s3  <= (phase_q == '0);
			phase_q <= (phase_q == PHASE_LAST) ? '0 : phase_q + PHASE_W'(1);
		end
	end

	// ---------------- Stage 4: decision and step multipliers ----------------
	assign start_fx   = AVG_W'({start_target_q, {FRAC_BITS{1'b0}}});
	assign backoff_fx = AVG_W'({backoff_target_q, {FRAC_BITS{1'b0}}});
	assign over_start = avg_q > start_fx;
	assign raise_diff = avg_q - start_fx;
	assign lower_diff = start_fx - avg_q;

	ltc_cdiv #(
		.XW  (FRAME_TIME_W),
		.DIV (RAISE_SPAN_US)
	) u_raise_div (
		.x (raise_diff[AVG_W-1:FRAC_BITS]),
		.q (raise_k)
	);

	ltc_cdiv #(
		.XW  (FRAME_TIME_W),
		.DIV (LOWER_SPAN_US)
	) u_lower_div (
		.x (lower_diff[AVG_W-1:FRAC_BITS]),
		.q (lower_k)
	);

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			raise_s4   <= act_s3 && over_start;
			lower_s4   <= act_s3 && !over_start && (avg_q <= backoff_fx);
			raise_k_s4 <= (raise_k >= FRAME_TIME_W'(RAISE_K_MAX)) ?
				RAISE_K_W'(RAISE_K_MAX) : raise_k[RAISE_K_W-1:0];
			// Only used when the average is at or below start, where it is at most 8.
			lower_k_s4 <= lower_k[LOWER_K_W-1:0];
			avg_us_s4  <= avg_q[AVG_W-1:FRAC_BITS];
		end
	end

	// ---------------- Stage 5: throttle update and result register ----------------
	assign raise_inc    = (LEVEL_W+1)'((10'(raise_k_s4) + 10'd1) * 10'(RAISE_STEP));
	assign raise_sum    = {1'b0, throttle_q} + raise_inc;
	assign level_raised = (raise_sum > (LEVEL_W+1)'(LEVEL_FULL)) ?
		LEVEL_FULL : raise_sum[LEVEL_W-1:0];
	assign lower_dec    = (LOWER_K_W+1)'(((LOWER_K_W+1)'(lower_k_s4) + (LOWER_K_W+1)'(1)) *
		(LOWER_K_W+1)'(LOWER_STEP));
	assign level_lowered = (LEVEL_W'(lower_dec) >= throttle_q) ?
		'0 : throttle_q - LEVEL_W'(lower_dec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= '0;
		end else if (en_s5 && valid_s4) begin
			if (raise_s4) begin
				throttle_q <= level_raised;
			end else if (lower_s4 && (throttle_q != '0)) begin
				throttle_q <= level_lowered;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4) begin
			avg_us_s5 <= avg_us_s4;
			if (raise_s4) begin
				event_s5 <= EVT_RAISE;
			end else if (lower_s4 && (throttle_q != '0)) begin
				event_s5 <= EVT_LOWER;
			end else begin
				event_s5 <= EVT_NONE;
			end
		end
	end

	assign result_valid    = valid_s5;
	assign throttle_level  = throttle_q;
	assign average_time_us = avg_us_s5;
	assign adjust_event    = event_s5;

	// ---------------- Assertions ----------------
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		throttle_q <= LEVEL_FULL)
		else $error("throttle level above full scale");

	a_branch_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> !(raise_s4 && lower_s4))
		else $error("raise and lower taken for the same frame");

	a_lower_decreases: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s5 && valid_s4 && !raise_s4 && lower_s4 && (throttle_q != '0)) |=>
		(throttle_q < $past(throttle_q)))
		else $error("lowering did not reduce the throttle level");

	a_avg_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!(en_s3 && valid_s2) |=> $stable(avg_q))
		else $error("average changed without a frame transaction");

endmodule
